// ----- hdl/dual_encoder_mt_speed_defines.svh -----
// Assertion macros for the dual encoder speed meter.
// Included by the top level; needs nothing else.
`ifndef DUAL_ENCODER_MT_SPEED_DEFINES_SVH
`define DUAL_ENCODER_MT_SPEED_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define DEMS_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define DEMS_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ----- hdl/dems_pkg.sv -----
// Shared types and constants of the dual encoder speed meter.
// No dependencies.
package dems_pkg;

   localparam int DEMS_Q_BITS = 24;

   // Magnitude widths of the speed numerator and denominator
   localparam int NUM_W = 39;
   localparam int DEN_W = 47;

   // Configuration register indexes
   localparam logic [2:0] CSR_SAMPLE_FREQ    = 3'd0;
   localparam logic [2:0] CSR_LINES_PER_REV  = 3'd1;
   localparam logic [2:0] CSR_MAX_SPEED_Q    = 3'd2;
   localparam logic [2:0] CSR_MIN_COUNT_STEP = 3'd3;
   localparam logic [2:0] CSR_JUMP_LIMIT_A   = 3'd4;
   localparam logic [2:0] CSR_JUMP_LIMIT_B   = 3'd5;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ABORT_A = 2'd1;
   localparam logic [1:0] STATUS_ABORT_B = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL1,
      ST_MUL2,
      ST_DIV1,
      ST_DIV2,
      ST_FILT1,
      ST_FILT2,
      ST_FILT3,
      ST_OUT
   } dems_state_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic               busy;
      logic               done;
      logic signed [31:0] quot;
   } dems_div_rsp_type;

endpackage

// ----- hdl/dems_if.sv -----
// Valid/ready channel interfaces of the dual encoder speed meter.
// Depends on nothing.
interface dems_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] count_a;
   logic signed [15:0] count_b;
   logic        [31:0] timestamp;

   modport source (output valid, count_a, count_b, timestamp, input ready);
   modport sink   (input valid, count_a, count_b, timestamp, output ready);
endinterface

interface dems_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] filtered_speed;
   logic signed [31:0] speed_a;
   logic signed [31:0] speed_b;
   logic        [1:0]  status;

   modport source (output valid, filtered_speed, speed_a, speed_b, status, input ready);
   modport sink   (input valid, filtered_speed, speed_a, speed_b, status, output ready);
endinterface

// ----- hdl/dems_div.sv -----
// Bit-serial restoring divider: min(floor(dividend / divisor), cap), signed result.
// Depends on dems_pkg.
module dems_div
   import dems_pkg::*;
#(
   parameter int Q_BITS = DEMS_Q_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        neg,
   input  logic [NUM_W+Q_BITS-1:0]     dividend,
   input  logic [DEN_W-1:0]            divisor,
   output dems_div_rsp_type            rsp
);

   localparam int DVD_W = NUM_W + Q_BITS;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] dvd_ff;
   logic [DEN_W-1:0] dvs_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [32:0]      q_ff;
   logic             ovf_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   trial;
   logic             fits;
   logic [32:0]      cap;
   logic [32:0]      mag;

   // One quotient bit per cycle
   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_W-1]};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
         q_ff   <= '0;
         ovf_ff <= 1'b0;
         neg_ff <= neg;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         rem_ff <= fits ? DEN_W'(trial - {1'b0, dvs_ff}) : trial[DEN_W-1:0];
         q_ff   <= {q_ff[31:0], fits};
         ovf_ff <= ovf_ff | q_ff[32];
      end
   end

   // Saturate and apply sign
   always_comb begin
      cap = neg_ff ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      mag = (ovf_ff || (q_ff > cap)) ? cap : q_ff;
      rsp.busy = busy_ff;
      rsp.done = done_ff;
      rsp.quot = neg_ff ? 32'(-mag) : mag[31:0];
   end

endmodule

// ----- hdl/dual_encoder_mt_speed.sv -----
// Dual encoder speed meter, top level.
// Each channel that needs a new speed runs two bit-serial divisions before the result
// is valid; a channel that needs no new speed skips them. The next item can be taken
// in the cycle after the result loads, also while a result waits in the output register.
// Reset (synchronous, active high) loads register defaults and clears the sequencer,
// channel state and output valid flag; work and payload registers are not reset.
`include "dual_encoder_mt_speed_defines.svh"

module dual_encoder_mt_speed
   import dems_pkg::*;
#(
   parameter int Q_BITS = DEMS_Q_BITS
) (
   input  logic        clock,
   input  logic        reset,
   dems_req_if.sink    req_chan,
   dems_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata
);

   localparam int DVD_W = NUM_W + Q_BITS;
   localparam logic [63:0] K_NINE = (64'd9 << Q_BITS) / 64'd10;
   localparam logic [63:0] K_ONE  = (64'd1 << Q_BITS) / 64'd10;

   // Configuration registers
   logic [15:0] freq_ff;
   logic [14:0] lines_ff;
   logic [30:0] maxq_ff;
   logic [14:0] min_step_ff;
   logic [15:0] jla_ff;
   logic [15:0] jlb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff     <= 16'd50000;
         lines_ff    <= 15'd10000;
         maxq_ff     <= 31'd1677721600;
         min_step_ff <= 15'd10;
         jla_ff      <= 16'd5000;
         jlb_ff      <= 16'd10000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAMPLE_FREQ:    freq_ff     <= csr_wdata[15:0];
            CSR_LINES_PER_REV:  lines_ff    <= csr_wdata[14:0];
            CSR_MAX_SPEED_Q:    maxq_ff     <= csr_wdata;
            CSR_MIN_COUNT_STEP: min_step_ff <= csr_wdata[14:0];
            CSR_JUMP_LIMIT_A:   jla_ff      <= csr_wdata[15:0];
            CSR_JUMP_LIMIT_B:   jlb_ff      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Channel state, indexed by channel
   logic [15:0]        last_count_ff [2];
   logic [31:0]        last_time_ff  [2];
   logic [31:0]        interval_ff   [2];
   logic [15:0]        step_ff       [2];
   logic signed [31:0] speed_ff      [2];
   logic signed [31:0] smooth_ff;

   // Item and work registers
   dems_state_type     state_ff, state_in;
   logic               ch_ff;
   logic [15:0]        cnt_ff [2];
   logic [31:0]        ts_ff;
   logic signed [16:0] diff_ff;
   logic [31:0]        dt_ff;
   logic [32:0]        p1_ff;
   logic [DEN_W-1:0]   den_ff;
   logic signed [63:0] m1_ff;
   logic signed [63:0] m2_ff;
   logic signed [31:0] avg_ff;
   logic [1:0]         status_ff, status_in;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_filt_ff, rsp_a_ff, rsp_b_ff;
   logic [1:0]         rsp_status_ff;

   // Setup decode for the current channel
   logic signed [16:0] cur_s, old_s, jdiff, dsx, dwrap, half, stp_sx;
   logic [16:0]        jump_mag;
   logic [15:0]        d16, limit;
   logic [31:0]        dt;
   logic               step_hit, jump_over, wrap, calc_ok;

   always_comb begin
      cur_s     = {cnt_ff[ch_ff][15], cnt_ff[ch_ff]};
      old_s     = {last_count_ff[ch_ff][15], last_count_ff[ch_ff]};
      jdiff     = old_s - cur_s;
      jump_mag  = jdiff[16] ? 17'(-jdiff) : jdiff;
      limit     = ch_ff ? jlb_ff : jla_ff;
      step_hit  = jump_mag > {2'b00, min_step_ff};
      jump_over = jump_mag > {1'b0, limit};
      d16       = cnt_ff[ch_ff] - last_count_ff[ch_ff];
      dsx       = {d16[15], d16};
      half      = {3'b000, lines_ff[14:1]};
      wrap      = (dsx > half) || (-dsx > half);
      dwrap     = (dsx > 17'sd0) ? dsx - $signed({2'b00, lines_ff})
                                 : dsx + $signed({2'b00, lines_ff});
      stp_sx    = {step_ff[ch_ff][15], step_ff[ch_ff]};
      dt        = ts_ff - last_time_ff[ch_ff];
      calc_ok   = (lines_ff != '0) && (dt != '0) && (maxq_ff != '0);
   end

   // Divider hookup
   dems_div_rsp_type     div_rsp;
   logic                 div_start, div_neg;
   logic [DVD_W-1:0]     div_dvd;
   logic [DEN_W-1:0]     div_dvs;
   logic [31:0]          rpm_mag;
   logic [NUM_W-1:0]     num;

   always_comb begin
      num     = NUM_W'(p1_ff) * NUM_W'(6'd60);
      rpm_mag = div_rsp.quot[31] ? 32'(-div_rsp.quot) : div_rsp.quot;
      if (state_ff == ST_MUL2) begin
         div_dvd = {num, {Q_BITS{1'b0}}};
         div_dvs = den_ff;
         div_neg = diff_ff[16];
      end else begin
         div_dvd = {{(NUM_W-32){1'b0}}, rpm_mag, {Q_BITS{1'b0}}};
         div_dvs = {{(DEN_W-31){1'b0}}, maxq_ff};
         div_neg = div_rsp.quot[31];
      end
   end

   dems_div #(.Q_BITS(Q_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .neg      (div_neg),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .rsp      (div_rsp)
   );

   // Sequencer: next state and strobes
   logic accept, chan_done, out_load;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      div_start = 1'b0;
      chan_done = 1'b0;
      out_load  = 1'b0;
      accept    = (state_ff == ST_IDLE) && req_chan.valid;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (step_hit && jump_over) begin
               status_in = ch_ff ? STATUS_ABORT_B : STATUS_ABORT_A;
               state_in  = ST_OUT;
            end else if ((step_hit || (dt > interval_ff[ch_ff])) && calc_ok) begin
               state_in = ST_MUL1;
            end else begin
               chan_done = 1'b1;
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: begin
            div_start = 1'b1;
            state_in  = ST_DIV1;
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               div_start = 1'b1;
               state_in  = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_rsp.done) chan_done = 1'b1;
         end
         ST_FILT1: state_in = ST_FILT2;
         ST_FILT2: state_in = ST_FILT3;
         ST_FILT3: begin
            status_in = STATUS_OK;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // Advance to channel B or the filter
      if (chan_done) state_in = ch_ff ? ST_FILT1 : ST_SETUP;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh0000_0000_7FFF_FFFF)       return 32'sh7FFF_FFFF;
      else if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
      else                                    return v[31:0];
   endfunction

   // Channel state and work registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            last_count_ff[i] <= '0;
            last_time_ff[i]  <= '0;
            interval_ff[i]   <= '0;
            step_ff[i]       <= '0;
            speed_ff[i]      <= '0;
         end
         smooth_ff <= '0;
         ch_ff     <= 1'b0;
         status_ff <= STATUS_OK;
      end else begin
         status_ff <= status_in;
         if (accept) ch_ff <= 1'b0;
         else if (chan_done) ch_ff <= 1'b1;
         if (state_ff == ST_SETUP && step_hit && !jump_over) begin
            step_ff[ch_ff]       <= wrap ? dwrap[15:0] : dsx[15:0];
            last_count_ff[ch_ff] <= cnt_ff[ch_ff];
            interval_ff[ch_ff]   <= dt;
            last_time_ff[ch_ff]  <= ts_ff;
         end
         if (state_ff == ST_DIV2 && div_rsp.done) speed_ff[ch_ff] <= div_rsp.quot;
         // Saturate the filter sum
         if (state_ff == ST_FILT3) begin
            smooth_ff <= sat32((m1_ff >>> Q_BITS) + (m2_ff >>> Q_BITS));
         end
      end
   end

   // Payload datapath
   logic signed [32:0] sum_ab;
   logic [16:0]        diff_mag;

   always_comb begin
      sum_ab   = {speed_ff[0][31], speed_ff[0]} + {speed_ff[1][31], speed_ff[1]};
      diff_mag = diff_ff[16] ? 17'(-diff_ff) : diff_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cnt_ff[0] <= req_chan.count_a;
         cnt_ff[1] <= req_chan.count_b;
         ts_ff     <= req_chan.timestamp;
      end
      if (state_ff == ST_SETUP) begin
         diff_ff <= step_hit ? (wrap ? dwrap : dsx) : stp_sx;
         dt_ff   <= dt;
      end
      if (state_ff == ST_MUL1) begin
         p1_ff  <= diff_mag * freq_ff;
         den_ff <= lines_ff * dt_ff;
      end
      if (state_ff == ST_FILT1) begin
         m1_ff  <= smooth_ff * $signed({1'b0, K_NINE[30:0]});
         avg_ff <= sum_ab[32:1];
      end
      if (state_ff == ST_FILT2) begin
         m2_ff <= avg_ff * $signed({1'b0, K_ONE[30:0]});
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_filt_ff   <= smooth_ff;
         rsp_a_ff      <= speed_ff[0];
         rsp_b_ff      <= speed_ff[1];
         rsp_status_ff <= status_ff;
      end
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.filtered_speed = rsp_filt_ff;
   assign rsp_chan.speed_a        = rsp_a_ff;
   assign rsp_chan.speed_b        = rsp_b_ff;
   assign rsp_chan.status         = rsp_status_ff;

   // Checks
   `DEMS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "ready stayed high after an item was taken")
   `DEMS_ASSERT_NOW(a_div_start_idle, clock, reset, div_start, !div_rsp.busy || div_rsp.done, "divider restarted while busy")
   `DEMS_ASSERT_NOW(a_div_in_div_state, clock, reset, div_rsp.busy, state_ff == ST_DIV1 || state_ff == ST_DIV2, "divider runs outside a divide state")

endmodule
